// ===== src/lc3_pkg.sv =====
// ----------------------------------------------------------------------------
// LC-3 core package
// Shared payload types, command and opcode codes, sequencer states.
// ----------------------------------------------------------------------------
package lc3_pkg;

  localparam int unsigned AddrBitsDefault = 16;
  localparam logic [15:0] StartReset = 16'h3000;

  localparam logic [1:0] CmdWrite = 2'd0;
  localparam logic [1:0] CmdExec  = 2'd1;
  localparam logic [1:0] CmdRead  = 2'd2;

  localparam logic [3:0] OpBr  = 4'd0;
  localparam logic [3:0] OpAdd = 4'd1;
  localparam logic [3:0] OpLd  = 4'd2;
  localparam logic [3:0] OpSt  = 4'd3;
  localparam logic [3:0] OpJsr = 4'd4;
  localparam logic [3:0] OpAnd = 4'd5;
  localparam logic [3:0] OpLdr = 4'd6;
  localparam logic [3:0] OpStr = 4'd7;
  localparam logic [3:0] OpNot = 4'd9;
  localparam logic [3:0] OpLdi = 4'd10;
  localparam logic [3:0] OpSti = 4'd11;
  localparam logic [3:0] OpJmp = 4'd12;
  localparam logic [3:0] OpLea = 4'd14;
  localparam logic [3:0] OpTrap = 4'd15;

  localparam logic [7:0] VecGetc = 8'h20;
  localparam logic [7:0] VecOut  = 8'h21;
  localparam logic [7:0] VecIn   = 8'h23;
  localparam logic [7:0] VecHalt = 8'h25;

  localparam logic [2:0] CcN = 3'd4;
  localparam logic [2:0] CcZ = 3'd2;
  localparam logic [2:0] CcP = 3'd1;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] address;
    logic [15:0] data;
    logic [7:0]  key_char;
  } lc3_in_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic [15:0] next_pc;
    logic [15:0] executed_word;
    logic [2:0]  condition;
    logic        char_valid;
    logic [7:0]  char_out;
    logic        halted;
    logic        fault;
  } lc3_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_DECODE,
    ST_IND,
    ST_LOAD,
    ST_DONE
  } lc3_state_t;

  // memory request from the sequencer
  typedef struct packed {
    logic        rd;
    logic        wr;
    logic [15:0] addr;
    logic [15:0] wdata;
  } lc3_mreq_t;

  function automatic logic [15:0] sext(input logic [15:0] v, input int unsigned bits);
    logic [15:0] r;
    r = v;
    for (int i = 0; i < 16; i++) begin
      if (i >= bits) begin
        r[i] = v[bits-1];
      end
    end
    return r;
  endfunction

  function automatic logic [2:0] cc_of(input logic [15:0] w);
    logic [2:0] c;
    if (w == 16'd0) begin
      c = CcZ;
    end else if (w[15]) begin
      c = CcN;
    end else begin
      c = CcP;
    end
    return c;
  endfunction

endpackage

// ===== src/lc3_mem.sv =====
// ----------------------------------------------------------------------------
// LC-3 main memory
// Single-port synchronous word memory with registered read.
// ----------------------------------------------------------------------------
module lc3_mem import lc3_pkg::*; #(
  parameter int unsigned ADDR_BITS = AddrBitsDefault
) (
  input  logic        clk,
  input  lc3_mreq_t   req,
  output logic [15:0] rdata
);

  logic [15:0] mem [2**ADDR_BITS];

  always_ff @(posedge clk) begin
    if (req.wr) begin
      mem[req.addr[ADDR_BITS-1:0]] <= req.wdata;
    end
    if (req.rd) begin
      rdata <= mem[req.addr[ADDR_BITS-1:0]];
    end
  end

endmodule

// ===== src/lc3_instruction_core.sv =====
// ----------------------------------------------------------------------------
// LC-3 instruction core
// Command-driven LC-3 with internal word memory, registers, PC and NZP code.
// ----------------------------------------------------------------------------
// Usage: each input transfer carries one command: write a memory word, read
// a memory word, or execute the instruction at the PC. Every command gives
// exactly one output transfer with the PC, condition code, status flags and,
// for reads, the memory word.
// Steps: write and read go from fetch to done; execute runs fetch, decode,
// then a load state for LD/LDR, an indirect state for STI, and both for LDI.
// One command is in flight at a time and the next is taken only after the
// output transfer. Memory words sit in the single-port main memory, one access
// per cycle; register file, PC, condition code and flags sit in the core.
// The cfg channel loads the PC; it is taken
// only while idle and goes ahead of a waiting command.
// Reset clears registers, sets PC to 0x3000, condition code to Z, and clears
// halt and fault. Memory is undefined until written.
// A stalled receiver holds the result register; in_ready stays low until the
// result is taken.
// ----------------------------------------------------------------------------
module lc3_instruction_core import lc3_pkg::*; #(
  parameter int unsigned ADDR_BITS = AddrBitsDefault
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  lc3_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output lc3_out_t out_data,
  input  logic     cfg_valid,
  output logic     cfg_ready,
  input  logic [15:0] cfg_data
);

  lc3_state_t  state, state_next;
  lc3_in_t     cmd;
  logic [15:0] regs [8];
  logic [15:0] pc, ins;
  logic [2:0]  cc;
  logic        stopped, faulted;
  lc3_mreq_t   req;
  logic [15:0] rdata;
  logic [15:0] a_val, b_val, pc1, ea_pc, ea_reg, pc_exec;
  logic [2:0]  dr;
  logic [15:0] exec_word;
  logic        chr_valid;
  logic [7:0]  chr_out;

  lc3_mem #(.ADDR_BITS(ADDR_BITS)) u_mem (.clk(clk), .req(req), .rdata(rdata));

  assign in_ready  = (state == ST_IDLE) && !cfg_valid;
  assign cfg_ready = (state == ST_IDLE);
  assign pc1    = pc + 16'd1;
  assign dr     = rdata[11:9];
  assign a_val  = regs[rdata[8:6]];
  assign b_val  = rdata[5] ? sext(rdata, 5) : regs[rdata[2:0]];
  assign ea_pc  = pc1 + sext(rdata, 9);
  assign ea_reg = a_val + sext(rdata, 6);

  always_comb begin
    pc_exec = pc1;
    case (rdata[15:12])
      OpBr: begin
        if ((dr & cc) != 3'd0) begin
          pc_exec = ea_pc;
        end
      end
      OpJsr: pc_exec = rdata[11] ? pc1 + sext(rdata, 11) : a_val;
      OpJmp: pc_exec = a_val;
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          state_next = ST_FETCH;
        end
      end
      ST_FETCH: begin
        if (cmd.opcode == CmdExec && !stopped && !faulted) begin
          state_next = ST_DECODE;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_DECODE: begin
        case (rdata[15:12])
          OpLd, OpLdr: state_next = ST_LOAD;
          OpLdi, OpSti: state_next = ST_IND;
          default: state_next = ST_DONE;
        endcase
      end
      ST_IND: begin
        state_next = (ins[15:12] == OpLdi) ? ST_LOAD : ST_DONE;
      end
      ST_LOAD: state_next = ST_DONE;
      ST_DONE: begin
        if (out_valid && out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req = '0;
    case (state)
      ST_FETCH: begin
        req.addr = (cmd.opcode == CmdExec) ? pc : cmd.address;
        req.wdata = cmd.data;
        req.rd = (cmd.opcode == CmdRead) ||
                 (cmd.opcode == CmdExec && !stopped && !faulted);
        req.wr = (cmd.opcode == CmdWrite);
      end
      ST_DECODE: begin
        req.wdata = regs[dr];
        case (rdata[15:12])
          OpLd, OpLdi, OpSti: begin
            req.addr = ea_pc;
            req.rd = 1'b1;
          end
          OpLdr: begin
            req.addr = ea_reg;
            req.rd = 1'b1;
          end
          OpSt: begin
            req.addr = ea_pc;
            req.wr = 1'b1;
          end
          OpStr: begin
            req.addr = ea_reg;
            req.wr = 1'b1;
          end
          default: req = '0;
        endcase
      end
      ST_IND: begin
        req.addr = rdata;
        req.wdata = regs[ins[11:9]];
        req.rd = (ins[15:12] == OpLdi);
        req.wr = (ins[15:12] == OpSti);
      end
      default: req = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
      pc <= StartReset;
      cc <= CcZ;
      stopped <= 1'b0;
      faulted <= 1'b0;
      exec_word <= '0;
      chr_valid <= 1'b0;
      chr_out <= '0;
      for (int i = 0; i < 8; i++) begin
        regs[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        pc <= cfg_data;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid && in_ready) begin
            cmd <= in_data;
            exec_word <= '0;
            chr_valid <= 1'b0;
            chr_out <= '0;
          end
        end
        ST_FETCH: begin
          if (cmd.opcode != CmdExec || stopped || faulted) begin
            out_valid <= 1'b1;
          end
        end
        ST_DECODE: begin
          ins <= rdata;
          exec_word <= rdata;
          pc <= pc_exec;
          case (rdata[15:12])
            OpAdd: begin
              regs[dr] <= a_val + b_val;
              cc <= cc_of(a_val + b_val);
            end
            OpAnd: begin
              regs[dr] <= a_val & b_val;
              cc <= cc_of(a_val & b_val);
            end
            OpNot: begin
              regs[dr] <= ~a_val;
              cc <= cc_of(~a_val);
            end
            OpLea: begin
              regs[dr] <= ea_pc;
              cc <= cc_of(ea_pc);
            end
            OpJsr: regs[7] <= pc1;
            OpTrap: begin
              case (rdata[7:0])
                VecGetc, VecIn: regs[0] <= {8'd0, cmd.key_char};
                VecOut: begin
                  chr_valid <= 1'b1;
                  chr_out <= regs[0][7:0];
                end
                VecHalt: stopped <= 1'b1;
                default: ;
              endcase
            end
            OpBr, OpJmp, OpLd, OpLdr, OpLdi, OpSti, OpSt, OpStr: ;
            default: faulted <= 1'b1;
          endcase
          if (state_next == ST_DONE) begin
            out_valid <= 1'b1;
          end
        end
        ST_IND: begin
          if (state_next == ST_DONE) begin
            out_valid <= 1'b1;
          end
        end
        ST_LOAD: begin
          regs[ins[11:9]] <= rdata;
          cc <= cc_of(rdata);
          out_valid <= 1'b1;
        end
        ST_DONE: begin
          if (out_ready) begin
            out_valid <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    out_data = '0;
    out_data.read_data = (cmd.opcode == CmdRead) ? rdata : 16'd0;
    out_data.next_pc = pc;
    out_data.executed_word = exec_word;
    out_data.condition = cc;
    out_data.char_valid = chr_valid;
    out_data.char_out = chr_out;
    out_data.halted = stopped;
    out_data.fault = faulted;
  end

  assert property (@(posedge clk) disable iff (rst) out_valid |-> state == ST_DONE)
    else $error("result shown outside done state");
  assert property (@(posedge clk) disable iff (rst) in_ready |-> !out_valid)
    else $error("input taken with result pending");
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && !out_ready) |=> $stable(pc))
    else $error("pc moved while stalled");

endmodule
